// File: hdl/sorted_list_engine_core_macros.svh
// Assertion macros used by the sorted list engine sequencer (sle_ctrl).
`ifndef SORTED_LIST_ENGINE_CORE_MACROS_SVH
`define SORTED_LIST_ENGINE_CORE_MACROS_SVH

// condition holds on every clock edge out of reset
`define SLE_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sle_pkg.sv
// Types, constants and helpers for the sorted list engine.
`default_nettype none
package sle_pkg;

    localparam int KEY_W            = 32;
    localparam int PAYLOAD_W        = 64;
    localparam int POS_W            = 7;
    localparam int COUNT_W          = 7;
    localparam int OP_W             = 2;
    localparam int STATUS_W         = 2;
    localparam int TDATA_W          = 104;
    localparam int DEF_CAPACITY     = 64;
    localparam int DEF_PAYLOAD_BITS = 64;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [COUNT_W-1:0]   count;
    } result_t;

    function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage
`default_nettype wire

// File: hdl/sle_ram.sv
// Simple dual-port entry memory, one write and one registered read per cycle.
`default_nettype none
module sle_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 96
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hdl/sle_ctrl.sv
// Sequencer: occupancy, search-and-shift walks over the entry memory, result forming.
`default_nettype none
module sle_ctrl #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire sle_pkg::op_t                       in_op,
    input  wire logic [sle_pkg::KEY_W-1:0]          in_key,
    input  wire logic [PAYLOAD_BITS-1:0]            in_payload,
    input  wire logic [sle_pkg::POS_W-1:0]          in_pos,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output sle_pkg::result_t                        res,
    output logic                                    wr_en,
    output logic [$clog2(CAPACITY)-1:0]             wr_addr,
    output logic [sle_pkg::KEY_W+PAYLOAD_BITS-1:0]  wr_data,
    output logic                                    rd_en,
    output logic [$clog2(CAPACITY)-1:0]             rd_addr,
    input  wire logic [sle_pkg::KEY_W+PAYLOAD_BITS-1:0] rd_data
);
    import sle_pkg::*;
    `include "sorted_list_engine_core_macros.svh"

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int ENTRY_W = KEY_W + PAYLOAD_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INS   = 6'b000010,
        S_SHIFT = 6'b000100,
        S_FETCH = 6'b001000,
        S_DEL   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        occ_reg, occ_next;
    op_t                     op_reg, op_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    status_t                 status_reg, status_next;
    logic [KEY_W-1:0]        fkey_reg, fkey_next;
    logic [PAYLOAD_W-1:0]    fpay_reg, fpay_next;

    logic [POS_W-1:0]        pos_eff;
    logic [CMP_W-1:0]        pos_wide;
    logic [CMP_W-1:0]        occ_wide;
    logic [CMP_W-1:0]        pos_slot;
    logic [CNT_W-1:0]        occ_m1;
    logic [ADDR_W-1:0]       idx_inc;
    logic                    full;
    logic                    idx_last;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    assign pos_eff  = (in_pos == '0) ? POS_W'(1) : in_pos;
    assign pos_wide = CMP_W'(pos_eff);
    assign occ_wide = CMP_W'(occ_reg);
    assign pos_slot = pos_wide - CMP_W'(1);
    assign occ_m1   = occ_reg - CNT_W'(1);
    assign idx_inc  = idx_reg + ADDR_W'(1);
    assign full     = (occ_reg == CNT_W'(CAPACITY));
    assign idx_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == occ_reg);
    assign rd_key   = rd_data[ENTRY_W-1 -: KEY_W];
    assign rd_pay   = rd_data[PAYLOAD_BITS-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        fkey_next    = fkey_reg;
        fpay_next    = fpay_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_inc;
        wr_data      = {key_reg, payload_reg};
        rd_en        = 1'b0;
        rd_addr      = idx_inc;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next      = in_op;
                    key_next     = in_key;
                    payload_next = in_payload;
                    status_next  = ST_DONE;
                    fkey_next    = '0;
                    fpay_next    = '0;
                    unique case (in_op) inside
                        OP_APPEND, OP_INSERT: begin
                            if (full) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else if (in_op == OP_APPEND || occ_reg == '0) begin
                                wr_en      = 1'b1;
                                wr_addr    = occ_reg[ADDR_W-1:0];
                                wr_data    = {in_key, in_payload};
                                occ_next   = occ_reg + CNT_W'(1);
                                state_next = S_DONE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_INS;
                            end
                        end
                        OP_DELETE, OP_READ: begin
                            if (occ_reg == '0 || pos_wide > occ_wide) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_slot[ADDR_W-1:0];
                                idx_next   = pos_slot[ADDR_W-1:0];
                                state_next = S_FETCH;
                            end
                        end
                    endcase
                end
            end
            S_INS: begin
                // scan from the head for the first key not below the new one
                if (key_less(rd_key, key_reg)) begin
                    if (idx_last) begin
                        wr_en      = 1'b1;
                        wr_addr    = idx_inc;
                        occ_next   = occ_reg + CNT_W'(1);
                        state_next = S_DONE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc;
                        idx_next = idx_inc;
                    end
                end else begin
                    wr_en        = 1'b1;
                    wr_addr      = idx_reg;
                    key_next     = rd_key;
                    payload_next = rd_pay;
                    rd_en        = !idx_last;
                    rd_addr      = idx_inc;
                    idx_next     = idx_inc;
                    state_next   = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // displaced entry rides in key_reg/payload_reg, one slot toward the tail
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (CNT_W'(idx_reg) == occ_reg) begin
                    occ_next   = occ_reg + CNT_W'(1);
                    state_next = S_DONE;
                end else begin
                    key_next     = rd_key;
                    payload_next = rd_pay;
                    rd_en        = !idx_last;
                    rd_addr      = idx_inc;
                    idx_next     = idx_inc;
                end
            end
            S_FETCH: begin
                fkey_next = rd_key;
                fpay_next = PAYLOAD_W'(rd_pay);
                if (op_reg == OP_READ) begin
                    state_next = S_DONE;
                end else if (idx_last) begin
                    occ_next   = occ_m1;
                    state_next = S_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc;
                    idx_next   = idx_inc;
                    state_next = S_DEL;
                end
            end
            S_DEL: begin
                // close the gap, moving entries up one slot
                wr_en   = 1'b1;
                wr_addr = idx_reg - ADDR_W'(1);
                wr_data = rd_data;
                if (idx_last) begin
                    occ_next   = occ_m1;
                    state_next = S_DONE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc;
                    idx_next = idx_inc;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        payload_reg <= payload_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        fkey_reg    <= fkey_next;
        fpay_reg    <= fpay_next;
    end

    always_comb begin
        res.status  = status_reg;
        res.key     = fkey_reg;
        res.payload = fpay_reg;
        res.count   = occ_wide[COUNT_W-1:0];
    end

    `SLE_ASSERT(a_occ_bound, occ_reg <= CNT_W'(CAPACITY), "occupancy above capacity")
    `SLE_ASSERT_IMP(a_wr_in_list, wr_en, CNT_W'(wr_addr) <= occ_reg, "write beyond list tail")
    `SLE_ASSERT_NEXT(a_done_hold, state_reg == S_DONE && !res_ready, state_reg == S_DONE, "lost")
    `SLE_ASSERT_NEXT(a_occ_stable, state_reg == S_DONE, $stable(occ_reg), "occupancy moved")

endmodule
`default_nettype wire

// File: hdl/sorted_list_engine_core.sv
// Top level: sorted list engine with stream ports and a registered result beat.
// Append, insert into an empty list and rejected operations complete without walking the
// entry memory; read fetches one entry; insert walks over the entries held; delete moves
// the entries after the deleted one toward the head.
// One item is in the sequencer at a time; walks over the memory and m_tready stalls delay the next.
// Synchronous active-low reset empties the list; entry contents are not cleared.
`default_nettype none
module sorted_list_engine_core #(
    parameter int CAPACITY     = sle_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = sle_pkg::DEF_PAYLOAD_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // record_key[31:0], record_payload[95:32], position[102:96], zero pad
    input  wire logic [sle_pkg::TDATA_W-1:0]   s_tdata,
    // operation[1:0]
    input  wire logic [sle_pkg::OP_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // found_key[31:0], found_payload[95:32], entry_count[102:96], zero pad
    output logic [sle_pkg::TDATA_W-1:0]        m_tdata,
    // status[1:0]
    output logic [sle_pkg::STATUS_W-1:0]       m_tuser
);
    import sle_pkg::*;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int ENTRY_W = KEY_W + PAYLOAD_BITS;
    localparam int PAD_W   = TDATA_W - KEY_W - PAYLOAD_W - COUNT_W;

    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               m_valid_reg;
    result_t            m_res_reg;

    sle_ctrl #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (op_t'(s_tuser)),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_payload (s_tdata[KEY_W +: PAYLOAD_BITS]),
        .in_pos     (s_tdata[KEY_W+PAYLOAD_W +: POS_W]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    sle_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{PAD_W{1'b0}}, m_res_reg.count, m_res_reg.payload, m_res_reg.key};

endmodule
`default_nettype wire
